// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define PPU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen.
`define PPU_NEVER(label, cond, msg) \
	`PPU_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/ppu_pkg.sv -----
package ppu_pkg;

	localparam int ROWS_PER_PATTERN = 64;
	localparam int MAX_CHANNELS     = 32;
	localparam int MAX_SAMPLES      = 64;

	localparam int ROW_W  = 6;
	localparam int CHAN_W = 5;
	localparam int CCNT_W = 6;
	localparam int MASK_W = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS_PER_PATTERN - 1);

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MASK   = 2'd2;

	localparam logic [CCNT_W-1:0] CHANNEL_COUNT_RST = 6'd32;

	// entry header flag bits (above the channel field)
	localparam int FLAG_NOTE = 0;
	localparam int FLAG_VOL  = 1;
	localparam int FLAG_EFX  = 2;

	localparam logic [7:0] NOTE_RAW_MIN = 8'hF0;
	localparam logic [7:0] NOTE_EMPTY   = 8'hFF;
	localparam logic [7:0] NOTE_BASE    = 8'd13;
	localparam logic [7:0] VOL_MAX      = 8'd64;

	// effect letters, 'A' = 1
	localparam logic [7:0] EFF_A = 8'd1;
	localparam logic [7:0] EFF_B = 8'd2;
	localparam logic [7:0] EFF_C = 8'd3;
	localparam logic [7:0] EFF_D = 8'd4;
	localparam logic [7:0] EFF_H = 8'd8;
	localparam logic [7:0] EFF_O = 8'd15;
	localparam logic [7:0] EFF_T = 8'd20;

	localparam logic [3:0] FX_NONE    = 4'h0;
	localparam logic [3:0] FX_SPEED   = 4'hF;
	localparam logic [3:0] FX_JUMP    = 4'hB;
	localparam logic [3:0] FX_BREAK   = 4'hD;
	localparam logic [3:0] FX_VSLIDE  = 4'hA;
	localparam logic [3:0] FX_VIBRATO = 4'h4;
	localparam logic [3:0] FX_OFFSET  = 4'h9;

	typedef enum logic [5:0] {
		PH_HEAD   = 6'b000001,
		PH_NOTE   = 6'b000010,
		PH_SAMPLE = 6'b000100,
		PH_VOL    = 6'b001000,
		PH_EFX    = 6'b010000,
		PH_ARG    = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [CCNT_W-1:0] channel_count;
		logic [7:0]        sample_count;
		logic [MASK_W-1:0] sample_present_mask;
	} cfg_t;

	typedef struct packed {
		logic [7:0] note;
		logic [7:0] sample;
		logic       sample_bad;
		logic [6:0] volume;
		logic [3:0] effect_code;
	} conv_t;

	typedef struct packed {
		logic [ROW_W-1:0]  row_index;
		logic [CHAN_W-1:0] channel_index;
		logic              has_note;
		logic [7:0]        note_number;
		logic [7:0]        sample_number;
		logic              sample_invalid;
		logic              has_volume;
		logic [6:0]        volume_level;
		logic              has_effect;
		logic [3:0]        effect_code;
		logic [7:0]        effect_param;
		logic              pattern_end;
	} cell_t;

	function automatic logic [3:0] map_effect(input logic [7:0] code);
		logic [3:0] r;
		case (code)
			EFF_A:   r = FX_SPEED;
			EFF_B:   r = FX_JUMP;
			EFF_C:   r = FX_BREAK;
			EFF_D:   r = FX_VSLIDE;
			EFF_H:   r = FX_VIBRATO;
			EFF_O:   r = FX_OFFSET;
			EFF_T:   r = FX_SPEED;
			default: r = FX_NONE;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/ppu_conv.sv -----
module ppu_conv (
	input  logic [7:0]    data_byte,
	input  ppu_pkg::cfg_t cfg,
	output ppu_pkg::conv_t conv
);

	logic [3:0] hi;
	logic [3:0] lo;
	logic [7:0] hi12;
	logic [7:0] smp_m1;
	logic       bad;

	assign hi     = data_byte[7:4];
	assign lo     = data_byte[3:0];
	assign hi12   = {1'b0, hi, 3'b000} + {2'b00, hi, 2'b00};
	assign smp_m1 = data_byte - 8'd1;

	always_comb begin
		if (data_byte > cfg.sample_count) begin
			bad = 1'b1;
		end else if (data_byte != 8'd0) begin
			bad = (data_byte > 8'(ppu_pkg::MAX_SAMPLES)) ||
				!cfg.sample_present_mask[smp_m1[5:0]];
		end else begin
			bad = 1'b0;
		end
	end

	always_comb begin
		if (data_byte < ppu_pkg::NOTE_RAW_MIN) begin
			conv.note = {4'd0, lo} + hi12 + ppu_pkg::NOTE_BASE;
		end else if (data_byte == ppu_pkg::NOTE_EMPTY) begin
			conv.note = 8'd0;
		end else begin
			conv.note = data_byte;
		end
		conv.sample      = bad ? 8'd0 : data_byte;
		conv.sample_bad  = bad;
		conv.volume      = (data_byte <= ppu_pkg::VOL_MAX) ? data_byte[6:0] + 7'd1 : 7'd0;
		conv.effect_code = ppu_pkg::map_effect(data_byte);
	end

endmodule

// ----- rtl/ppu_parser.sv -----
module ppu_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [7:0]     data_byte,
	input  ppu_pkg::cfg_t  cfg,
	output logic           emit,
	output ppu_pkg::cell_t decoded
);

	ppu_pkg::phase_t            phase_q, phase_n;
	logic [ppu_pkg::ROW_W-1:0]  row_q, row_n;
	logic [2:0]                 flags_q, flags_n;
	logic [ppu_pkg::CHAN_W-1:0] chan_q, chan_n;
	logic                       skip_q, skip_n;
	logic [7:0]                 note_q, note_n;
	logic [7:0]                 sample_q, sample_n;
	logic                       bad_q, bad_n;
	logic [6:0]                 vol_q, vol_n;
	logic [3:0]                 efx_q, efx_n;
	logic [ppu_pkg::CCNT_W-1:0] limit;
	logic                       finish;
	ppu_pkg::conv_t             conv;

	ppu_conv u_conv (
		.data_byte (data_byte),
		.cfg       (cfg),
		.conv      (conv)
	);

	assign limit = (cfg.channel_count > ppu_pkg::CCNT_W'(ppu_pkg::MAX_CHANNELS)) ?
		ppu_pkg::CCNT_W'(ppu_pkg::MAX_CHANNELS) : cfg.channel_count;

	always_comb begin
		phase_n  = phase_q;
		row_n    = row_q;
		flags_n  = flags_q;
		chan_n   = chan_q;
		skip_n   = skip_q;
		note_n   = note_q;
		sample_n = sample_q;
		bad_n    = bad_q;
		vol_n    = vol_q;
		efx_n    = efx_q;
		finish   = 1'b0;
		emit     = 1'b0;
		decoded  = '0;
		case (phase_q)
			ppu_pkg::PH_NOTE: begin
				note_n  = conv.note;
				phase_n = ppu_pkg::PH_SAMPLE;
			end
			ppu_pkg::PH_SAMPLE: begin
				sample_n = conv.sample;
				bad_n    = conv.sample_bad;
				if (flags_q[ppu_pkg::FLAG_VOL]) begin
					phase_n = ppu_pkg::PH_VOL;
				end else if (flags_q[ppu_pkg::FLAG_EFX]) begin
					phase_n = ppu_pkg::PH_EFX;
				end else begin
					finish = 1'b1;
				end
			end
			ppu_pkg::PH_VOL: begin
				vol_n = conv.volume;
				if (flags_q[ppu_pkg::FLAG_EFX]) begin
					phase_n = ppu_pkg::PH_EFX;
				end else begin
					finish = 1'b1;
				end
			end
			ppu_pkg::PH_EFX: begin
				efx_n   = conv.effect_code;
				phase_n = ppu_pkg::PH_ARG;
			end
			ppu_pkg::PH_ARG: begin
				finish = 1'b1;
			end
			ppu_pkg::PH_HEAD: begin
				if (data_byte == 8'd0) begin
					if (row_q == ppu_pkg::LAST_ROW) begin
						row_n               = '0;
						emit                = 1'b1;
						decoded.pattern_end = 1'b1;
					end else begin
						row_n = row_q + ppu_pkg::ROW_W'(1);
					end
				end else begin
					chan_n   = data_byte[ppu_pkg::CHAN_W-1:0];
					flags_n  = data_byte[7:5];
					skip_n   = {1'b0, chan_n} >= limit;
					note_n   = '0;
					sample_n = '0;
					bad_n    = 1'b0;
					vol_n    = '0;
					efx_n    = '0;
					if (flags_n[ppu_pkg::FLAG_NOTE]) begin
						phase_n = ppu_pkg::PH_NOTE;
					end else if (flags_n[ppu_pkg::FLAG_VOL]) begin
						phase_n = ppu_pkg::PH_VOL;
					end else if (flags_n[ppu_pkg::FLAG_EFX]) begin
						phase_n = ppu_pkg::PH_EFX;
					end else begin
						finish = 1'b1;
					end
				end
			end
			default: begin
				phase_n = ppu_pkg::PH_HEAD;
			end
		endcase

		if (finish) begin
			phase_n = ppu_pkg::PH_HEAD;
			if (!skip_n) begin
				emit                  = 1'b1;
				decoded.row_index     = row_q;
				decoded.channel_index = chan_n;
				if (flags_n[ppu_pkg::FLAG_NOTE]) begin
					decoded.has_note       = 1'b1;
					decoded.note_number    = note_n;
					decoded.sample_number  = sample_n;
					decoded.sample_invalid = bad_n;
				end
				if (flags_n[ppu_pkg::FLAG_VOL]) begin
					decoded.has_volume   = 1'b1;
					decoded.volume_level = vol_n;
				end
				if (flags_n[ppu_pkg::FLAG_EFX]) begin
					decoded.has_effect   = 1'b1;
					decoded.effect_code  = efx_n;
					decoded.effect_param = (efx_n != ppu_pkg::FX_NONE) ? data_byte : 8'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ppu_pkg::PH_HEAD;
			row_q    <= '0;
			flags_q  <= '0;
			chan_q   <= '0;
			skip_q   <= 1'b0;
			note_q   <= '0;
			sample_q <= '0;
			bad_q    <= 1'b0;
			vol_q    <= '0;
			efx_q    <= '0;
		end else if (fire) begin
			phase_q  <= phase_n;
			row_q    <= row_n;
			flags_q  <= flags_n;
			chan_q   <= chan_n;
			skip_q   <= skip_n;
			note_q   <= note_n;
			sample_q <= sample_n;
			bad_q    <= bad_n;
			vol_q    <= vol_n;
			efx_q    <= efx_n;
		end
	end

endmodule

// ----- rtl/packed_pattern_unpacker.sv -----
// Packed pattern unpacker: takes one packed pattern byte per transaction on the
// byte channel and returns one decoded cell per completed in-use entry, plus a
// pattern_end cell after the 64th row end. Bytes are taken every cycle while
// byte_stall is low; a byte is held in the input register, and its cell, if
// any, is registered in the output register on the cell channel. The only thing
// that slows input is cell_stall: byte_stall rises when a cell is waiting and
// the input register already holds a byte. Write the configuration registers
// only while no entry is in flight.
module packed_pattern_unpacker (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,

	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,

	output logic        cell_valid,
	input  logic        cell_stall,
	output logic [5:0]  row_index,
	output logic [4:0]  channel_index,
	output logic        has_note,
	output logic [7:0]  note_number,
	output logic [7:0]  sample_number,
	output logic        sample_invalid,
	output logic        has_volume,
	output logic [6:0]  volume_level,
	output logic        has_effect,
	output logic [3:0]  effect_code,
	output logic [7:0]  effect_param,
	output logic        pattern_end
);

	ppu_pkg::cfg_t  cfg_q;
	logic [7:0]     byte_s1;
	logic           valid_s1;
	logic           advance;
	logic           fire;
	logic           emit;
	ppu_pkg::cell_t decoded;
	ppu_pkg::cell_t cell_q;
	logic           cell_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count       <= ppu_pkg::CHANNEL_COUNT_RST;
			cfg_q.sample_count        <= '0;
			cfg_q.sample_present_mask <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				ppu_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[ppu_pkg::CCNT_W-1:0];
				ppu_pkg::REG_SAMPLE_COUNT:  cfg_q.sample_count <= cfg_data[7:0];
				ppu_pkg::REG_SAMPLE_MASK:   cfg_q.sample_present_mask <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance    = !cell_valid_q || !cell_stall;
	assign fire       = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
		end
	end

	ppu_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (byte_s1),
		.cfg       (cfg_q),
		.emit      (emit),
		.decoded   (decoded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_q <= 1'b0;
		end else if (advance) begin
			cell_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire && emit) begin
			cell_q <= decoded;
		end
	end

	assign cell_valid     = cell_valid_q;
	assign row_index      = cell_q.row_index;
	assign channel_index  = cell_q.channel_index;
	assign has_note       = cell_q.has_note;
	assign note_number    = cell_q.note_number;
	assign sample_number  = cell_q.sample_number;
	assign sample_invalid = cell_q.sample_invalid;
	assign has_volume     = cell_q.has_volume;
	assign volume_level   = cell_q.volume_level;
	assign has_effect     = cell_q.has_effect;
	assign effect_code    = cell_q.effect_code;
	assign effect_param   = cell_q.effect_param;
	assign pattern_end    = cell_q.pattern_end;

endmodule

// ----- rtl/ppu_checker.sv -----
`include "assert_macros.svh"

module ppu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cell_valid,
	input logic       cell_stall,
	input logic [5:0] row_index,
	input logic [4:0] channel_index,
	input logic       has_note,
	input logic [7:0] note_number,
	input logic [7:0] sample_number,
	input logic       sample_invalid,
	input logic       has_volume,
	input logic [6:0] volume_level,
	input logic       has_effect,
	input logic [3:0] effect_code,
	input logic [7:0] effect_param,
	input logic       pattern_end
);

	`PPU_ASSERT(a_stall_hold, cell_valid && cell_stall |=> cell_valid && $stable(row_index) && $stable(channel_index) && $stable(pattern_end), "stalled cell changed")
	`PPU_NEVER(a_end_clean, cell_valid && pattern_end && (row_index != 6'd0 || channel_index != 5'd0 || has_note || has_volume || has_effect), "pattern end carries cell data")
	`PPU_NEVER(a_note_absent, cell_valid && !has_note && (note_number != 8'd0 || sample_number != 8'd0 || sample_invalid), "note fields without note flag")
	`PPU_NEVER(a_bad_sample, cell_valid && sample_invalid && sample_number != 8'd0, "rejected sample not zeroed")
	`PPU_NEVER(a_fx_param, cell_valid && (effect_code == 4'd0) && (effect_param != 8'd0 || (!has_effect && volume_level > 7'd65)), "effect parameter on empty effect")

endmodule

bind packed_pattern_unpacker ppu_checker u_ppu_checker (.*);
